// ----- src/cb32_pkg.sv -----
// Shared types, character codes and the symbol map for the Crockford base32 decoder.
package cb32_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned SYM_W   = 5;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned STORE_W = 7;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned ACC_W   = STORE_W + SYM_W;

    // Characters that are passed over without effect
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;

    // Lower-case range and the offset that folds it onto upper case
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_FOLD  = 8'h20;

    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] val;
    } sym_t;

    function automatic logic is_skip(input logic [CHAR_W-1:0] ch);
        return (ch == CH_SPACE) || (ch == CH_HYPHEN) || (ch == CH_LF) ||
               (ch == CH_CR) || (ch == CH_TAB);
    endfunction

    // Map a character to its 5-bit symbol; ok is low for anything outside the alphabet
    function automatic sym_t sym_lookup(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] up;
        sym_t              s;
        up = ch;
        if ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z))
        begin
            up = ch - CASE_FOLD;
        end
        s.ok = 1'b1;
        unique case (up)
            8'h30:   s.val = 5'd0;   // 0
            8'h31:   s.val = 5'd1;
            8'h32:   s.val = 5'd2;
            8'h33:   s.val = 5'd3;
            8'h34:   s.val = 5'd4;
            8'h35:   s.val = 5'd5;
            8'h36:   s.val = 5'd6;
            8'h37:   s.val = 5'd7;
            8'h38:   s.val = 5'd8;
            8'h39:   s.val = 5'd9;   // 9
            8'h41:   s.val = 5'd10;  // A
            8'h42:   s.val = 5'd11;
            8'h43:   s.val = 5'd12;
            8'h44:   s.val = 5'd13;
            8'h45:   s.val = 5'd14;
            8'h46:   s.val = 5'd15;
            8'h47:   s.val = 5'd16;
            8'h48:   s.val = 5'd17;  // H
            8'h49:   s.val = 5'd1;   // I reads as one
            8'h4A:   s.val = 5'd18;  // J
            8'h4B:   s.val = 5'd19;
            8'h4C:   s.val = 5'd1;   // L reads as one
            8'h4D:   s.val = 5'd20;  // M
            8'h4E:   s.val = 5'd21;
            8'h4F:   s.val = 5'd0;   // O reads as zero
            8'h50:   s.val = 5'd22;  // P
            8'h51:   s.val = 5'd23;
            8'h52:   s.val = 5'd24;
            8'h53:   s.val = 5'd25;
            8'h54:   s.val = 5'd26;  // T
            8'h55:   s.val = 5'd27;  // U reads as V
            8'h56:   s.val = 5'd27;  // V
            8'h57:   s.val = 5'd28;
            8'h58:   s.val = 5'd29;
            8'h59:   s.val = 5'd30;
            8'h5A:   s.val = 5'd31;  // Z
            default:
            begin
                s.ok  = 1'b0;
                s.val = '0;
            end
        endcase
        return s;
    endfunction

endpackage

// ----- src/crockford_base32_decoder.sv -----
// Top level of the Crockford base32 decoder: input register, symbol map, bit packer, result register.
//
//   Channel   Dir  Signals                        Content
//   s_axis    in   tvalid tready tdata tlast      one text character, tlast on the last one
//   m_axis    out  tvalid tready tdata tuser tlast decoded byte and end-of-code status
//
// Each character is held in the input register; one that makes a result is then loaded into the
// result register, from which it is offered on m_axis; one character per cycle is sustained
// while m_axis does not stall, the limit being the update of the small bit store.
// Reset (rst_n low, asynchronous) empties both registers and clears the bit store, the bit
// count and the sticky failure flag.
// A stall on m_axis holds the result register, and the input register when its character
// makes a result; s_axis tready drops only once both are occupied, the held character makes
// a result and the waiting result is not being taken.
// Characters that make no result leave the input register without waiting for m_axis.
module crockford_base32_decoder
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] code_char
    input  logic       s_axis_tlast,   // last_char

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic [1:0] m_axis_tuser,   // [0] has_byte, [1] decode_ok
    output logic       m_axis_tlast    // end_of_code
);

    // Input register
    logic                                 in_valid_reg;
    logic [cb32_pkg::CHAR_W-1:0]          in_char_reg;
    logic                                 in_last_reg;

    // Decoder state
    logic [cb32_pkg::STORE_W-1:0]         store_reg;
    logic [cb32_pkg::STORE_W-1:0]         store_next;
    logic [cb32_pkg::COUNT_W-1:0]         count_reg;
    logic [cb32_pkg::COUNT_W-1:0]         count_next;
    logic                                 failed_reg;
    logic                                 failed_next;

    // Result register
    logic                                 out_valid_reg;
    logic [cb32_pkg::BYTE_W-1:0]          out_byte_reg;
    logic                                 out_has_reg;
    logic                                 out_end_reg;
    logic                                 out_ok_reg;

    // Combinational decode of the held character
    cb32_pkg::sym_t                       sym;
    logic [cb32_pkg::ACC_W-1:0]           acc;
    logic [cb32_pkg::COUNT_W:0]           cnt_sum;
    logic [cb32_pkg::COUNT_W-1:0]         shift;
    logic                                 got_byte;
    logic [cb32_pkg::BYTE_W-1:0]          byte_val;
    logic                                 emit;
    logic                                 out_free;
    logic                                 advance;

    // The result register can take a new result when it is empty or being emptied
    assign out_free      = !out_valid_reg || m_axis_tready;
    // The held character leaves when it makes no result or the result register is free
    assign advance       = in_valid_reg && (!emit || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        sym         = cb32_pkg::sym_lookup(in_char_reg);
        acc         = {store_reg, sym.val};
        cnt_sum     = {1'b0, count_reg} + 4'd5;
        got_byte    = 1'b0;
        byte_val    = '0;
        shift       = '0;
        store_next  = store_reg;
        count_next  = count_reg;
        failed_next = failed_reg;

        if (!failed_reg && !cb32_pkg::is_skip(in_char_reg))
        begin
            if (!sym.ok)
            begin
                failed_next = 1'b1;
            end
            else
            begin
                count_next = cnt_sum[cb32_pkg::COUNT_W-1:0];
                if (cnt_sum[cb32_pkg::COUNT_W])
                begin
                    // Eight or more bits held: the oldest eight leave as a byte
                    shift    = cnt_sum[cb32_pkg::COUNT_W-1:0];
                    byte_val = cb32_pkg::BYTE_W'(acc >> shift);
                    got_byte = 1'b1;
                end
                // Keep only the bits still pending
                store_next = cb32_pkg::STORE_W'(acc &
                             ((cb32_pkg::ACC_W'(1) << count_next) - cb32_pkg::ACC_W'(1)));
            end
        end

        emit = got_byte || in_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            store_reg     <= '0;
            count_reg     <= '0;
            failed_reg    <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end

            if (advance)
            begin
                if (in_last_reg)
                begin
                    // End of code: drop leftover bits and start afresh
                    store_reg  <= '0;
                    count_reg  <= '0;
                    failed_reg <= 1'b0;
                end
                else
                begin
                    store_reg  <= store_next;
                    count_reg  <= count_next;
                    failed_reg <= failed_next;
                end
            end

            if (out_free)
            begin
                out_valid_reg <= advance && emit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && emit)
        begin
            out_byte_reg <= byte_val;
            out_has_reg  <= got_byte;
            out_end_reg  <= in_last_reg;
            out_ok_reg   <= in_last_reg && !failed_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_ok_reg, out_has_reg};
    assign m_axis_tlast  = out_end_reg;

    // Pending bits above the count must always be zero
    assert_store_clean : assert property (@(posedge clk) disable iff (!rst_n)
        (cb32_pkg::ACC_W'(store_reg) >> count_reg) == '0)
        else $error("bit store holds bits beyond its count");

    // Closing a code leaves the state cleared
    assert_end_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (count_reg == '0 && store_reg == '0 && !failed_reg))
        else $error("state not cleared after end of code");

    // A result without a byte can only be the end-of-code result
    assert_empty_is_end : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("result carries neither byte nor end mark");

    // No byte follows a failure
    assert_ok_at_end : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && got_byte) |-> !failed_reg)
        else $error("byte produced after a failure");

endmodule

// ----- sim/crockford_base32_decoder_tb.sv -----
// Self-checking testbench for the Crockford base32 decoder: directed and random codes.
`timescale 1ns / 100ps

module crockford_base32_decoder_tb;

    // One decoded result as it leaves m_axis
    typedef struct packed {
        logic [cb32_pkg::BYTE_W-1:0] data_byte;
        logic                        has_byte;
        logic                        end_of_code;
        logic                        decode_ok;
    } decoded_t;

    // Tracks the decoder state from accepted characters and holds the bytes it should emit
    class decode_tracker;
        string         alphabet = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
        logic [6:0]    pend_bits;
        logic [2:0]    pend_count;
        bit            failed;
        decoded_t      pending_q[$];
        int unsigned   errors;

        function new();
            pend_bits  = '0;
            pend_count = '0;
            failed     = 1'b0;
            errors     = 0;
        endfunction

        task report(input string what);
            $display("%0t ns  mismatch: %s", $time, what);
            errors++;
        endtask

        function bit is_blank(input logic [7:0] ch);
            return (ch == cb32_pkg::CH_SPACE) || (ch == cb32_pkg::CH_HYPHEN) ||
                   (ch == cb32_pkg::CH_LF) || (ch == cb32_pkg::CH_CR) ||
                   (ch == cb32_pkg::CH_TAB);
        endfunction

        // Fold case and the look-alike letters, then find the symbol in the alphabet
        function bit symbol_of(input logic [7:0] ch, output logic [4:0] sym);
            logic [7:0] up;
            up  = ch;
            sym = '0;
            if (up >= "a" && up <= "z")
            begin
                up = up - 8'd32;
            end
            if (up == "I" || up == "L")
            begin
                up = "1";
            end
            else if (up == "O")
            begin
                up = "0";
            end
            else if (up == "U")
            begin
                up = "V";
            end
            for (int i = 0; i < 32; i++)
            begin
                if (alphabet[i] == up)
                begin
                    sym = i[4:0];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Advance the bit packer by one character and queue whatever it produces
        function void note_char(input logic [7:0] ch, input logic is_last);
            logic [4:0]  sym;
            logic [11:0] acc;
            logic [3:0]  cnt;
            decoded_t    r;
            r = '0;
            if (!failed && !is_blank(ch))
            begin
                if (!symbol_of(ch, sym))
                begin
                    failed = 1'b1;
                end
                else
                begin
                    acc = {pend_bits, sym};
                    cnt = {1'b0, pend_count} + 4'd5;
                    if (cnt >= 4'd8)
                    begin
                        r.data_byte = 8'(acc >> (cnt - 4'd8));
                        r.has_byte  = 1'b1;
                        cnt         = cnt - 4'd8;
                    end
                    pend_count = cnt[2:0];
                    pend_bits  = acc[6:0] & ~(7'h7F << cnt);
                end
            end
            if (is_last)
            begin
                r.end_of_code = 1'b1;
                r.decode_ok   = !failed;
                pending_q     = {pending_q, r};
                pend_bits  = '0;
                pend_count = '0;
                failed     = 1'b0;
            end
            else if (r.has_byte)
            begin
                pending_q = {pending_q, r};
            end
        endfunction

        task check_result(input logic [7:0] data, input logic [1:0] flags, input logic eoc);
            decoded_t e;
            if (pending_q.size() == 0)
            begin
                report($sformatf("result %02h/%b/%b with nothing outstanding", data, flags, eoc));
                return;
            end
            e = pending_q.pop_front();
            if (data !== e.data_byte)
                report($sformatf("data_byte %02h, want %02h", data, e.data_byte));
            if (flags[0] !== e.has_byte)
                report($sformatf("has_byte %b, want %b", flags[0], e.has_byte));
            if (eoc !== e.end_of_code)
                report($sformatf("end_of_code %b, want %b", eoc, e.end_of_code));
            if (flags[1] !== e.decode_ok)
                report($sformatf("decode_ok %b, want %b", flags[1], e.decode_ok));
        endtask
    endclass

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       s_axis_tvalid  = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata   = '0;
    logic       s_axis_tlast   = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready  = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    // While set, neither side idles nor stalls
    bit          calm       = 1'b0;
    int unsigned chars_sent = 0;

    decode_tracker tracker = new();

    crockford_base32_decoder DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Stall the result side in roughly a quarter of the cycles
    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 27);
    end

    // Sample both handshakes at the edge: note the character before checking any result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_char(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // Offer one character, idling first at random, and hold it until it is taken
    task automatic send_char(input logic [7:0] ch, input logic is_last);
        while (!calm && $urandom_range(0, 99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        chars_sent++;
    endtask

    // Send a whole code, flagging its final character
    task automatic send_code(input string code);
        for (int i = 0; i < code.len(); i++)
            send_char(code[i], i == code.len() - 1);
    endtask

    // Pick one character that belongs in a well-formed code: any case, aliases, separators
    function automatic logic [7:0] code_char_pick();
        string      glyphs;
        logic [7:0] blanks [5];
        glyphs = "0123456789ABCDEFGHJKMNPQRSTVWXYZabcdefghjkmnpqrstvwxyzIiLlOoUu";
        blanks = '{cb32_pkg::CH_SPACE, cb32_pkg::CH_HYPHEN, cb32_pkg::CH_LF,
                   cb32_pkg::CH_CR, cb32_pkg::CH_TAB};
        if ($urandom_range(0, 99) < 12)
            return blanks[$urandom_range(0, 4)];
        return glyphs[$urandom_range(0, glyphs.len() - 1)];
    endfunction

    initial
    begin
        int unsigned kind;
        int unsigned len;
        int unsigned bad_at;
        logic [7:0]  ch;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All-ones symbols, with the final character completing a byte
        send_code("ZZZZZZZZ");
        // Lower case, look-alike letters and a hyphen, ending on U
        send_code("oIl-U");
        // Code ending on separators: the end mark must still arrive
        send_code("0 \t\r\n");
        // Invalid high byte, a character ignored after failure, and a failed end
        send_char("A", 1'b0);
        send_char(8'h80, 1'b0);
        send_char("B", 1'b0);
        send_char(8'hFF, 1'b1);
        // A lone control character as the whole code
        send_char(8'h00, 1'b1);

        // Mostly clean codes of random content, some with one stray byte, some pure noise
        while (chars_sent < 950)
        begin
            calm   = (chars_sent >= 350) && (chars_sent < 520);
            kind   = $urandom_range(0, 99);
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                 : $urandom_range(1, 16);
            bad_at = (kind >= 70 && kind < 85) ? $urandom_range(0, len - 1) : len;
            for (int i = 0; i < len; i++)
            begin
                if (kind >= 85 || i == bad_at)
                    ch = 8'($urandom_range(0, 255));
                else
                    ch = code_char_pick();
                send_char(ch, i == len - 1);
            end
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        // Let the monitor see the final handshake, drain, then allow for the pipeline
        @(posedge clk);
        while (tracker.pending_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
